// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the voice allocator RTL.
// Both macros sample on clk and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define VPA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define VPA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/core/vpa_pkg.sv
// ----------------------------------------------------------------------------
// vpa_pkg
// Types, codes and constants of the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

	// Controller numbers and limits.
	localparam logic [6:0] CC_SUSTAIN      = 7'd64;
	localparam logic [6:0] CC_SOUND_OFF    = 7'd120;
	localparam logic [6:0] CC_NOTES_OFF    = 7'd123;
	localparam logic [6:0] PEDAL_THRESHOLD = 7'd64;
	localparam logic [6:0] MAX_VALUE       = 7'd127;
	localparam logic [5:0] MAX_RESULTS     = 6'd32;

	// Configuration register indexes.
	localparam logic [1:0] CFG_STEAL_MODE     = 2'd0;
	localparam logic [1:0] CFG_SUSTAIN_ENABLE = 2'd1;
	localparam logic [1:0] CFG_VOICE_LIMIT    = 2'd2;

	typedef enum logic [1:0] {
		OP_NOTE_ON  = 2'd0,
		OP_NOTE_OFF = 2'd1,
		OP_CONTROL  = 2'd2,
		OP_FINISHED = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ACT_NONE      = 3'd0,
		ACT_NEW       = 3'd1,
		ACT_RETRIGGER = 3'd2,
		ACT_STOLEN    = 3'd3,
		ACT_SUSTAINED = 3'd4,
		ACT_RELEASED  = 3'd5,
		ACT_FREED     = 3'd6,
		ACT_FAILED    = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		STEAL_OLDEST   = 2'd0,
		STEAL_LOW_VEL  = 2'd1,
		STEAL_HIGH_NOTE = 2'd2,
		STEAL_LOW_NOTE = 2'd3
	} steal_t;

	// Decoded class of the event being worked on.
	typedef enum logic [2:0] {
		K_NOTE_ON,
		K_NOTE_OFF,
		K_PEDAL,
		K_SOUND_OFF,
		K_NOTES_OFF,
		K_FINISH,
		K_NONE
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_SCAN,
		ST_ACT,
		ST_FLUSH,
		ST_SWEEP
	} state_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [6:0] note;
		logic [6:0] velocity;
		logic [3:0] channel;
		logic [6:0] cc_number;
		logic [6:0] cc_value;
		logic [4:0] voice_slot;
	} event_t;

	typedef struct packed {
		logic [4:0]  voice_index;
		logic [2:0]  action;
		logic [6:0]  out_note;
		logic [6:0]  out_velocity;
		logic [15:0] voice_id;
		logic [5:0]  active_count;
		logic [15:0] steal_count;
		logic        last;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic act;
		logic flush;
		logic sweep;
		logic cfg_we;
	} vpa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		kind_t kind;
		logic  scan_done;
		logic  sweep_last;
		logic  go;
		logic  out_free;
		logic  pedal_rel;
	} vpa_sts_t;

	function automatic result_t mk_res(
		input logic [4:0]  idx,
		input action_t     act,
		input logic [6:0]  nt,
		input logic [6:0]  vl,
		input logic [15:0] id,
		input logic [5:0]  ac,
		input logic [15:0] sc
	);
		result_t r;
		r.voice_index  = idx;
		r.action       = act;
		r.out_note     = nt;
		r.out_velocity = vl;
		r.voice_id     = id;
		r.active_count = ac;
		r.steal_count  = sc;
		r.last         = 1'b0;
		return r;
	endfunction

endpackage

// File: rtl/core/poly_voice_allocator.sv
// ----------------------------------------------------------------------------
// poly_voice_allocator
// Polyphonic voice allocator with voice stealing: synth events in, one
// result beat per voice slot changed out, or a single beat when none changes.
//
//   Channel   Handshake            Beat
//   event     event_valid/stall    event_t: one synth event
//   result    result_valid/stall   result_t: one affected slot
//   cfg       cfg_valid/ready      register index and 6-bit data
//
// From acceptance an event runs decode, a scan of the slots below the voice
// limit, an action, a flush and an idle state before the next acceptance;
// each class takes only the steps it needs, a pedal release acting first.
// A voice_limit write starts a clearing pass over all VOICES slots; events wait.
// Reset is asynchronous and puts the table to all slots free.
// A stalled result holds the scan; the next event is taken while the last
// result of the previous one still waits.
// ----------------------------------------------------------------------------
module poly_voice_allocator
	import vpa_pkg::*;
#(
	parameter int VOICES   = 32,
	parameter int CHANNELS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       event_valid,
	output logic       event_stall,
	input  event_t     event_item,
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result_item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data
);

	vpa_cmd_t cmd;
	vpa_sts_t sts;

	// Sequencer.
	vpa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.sts         (sts),
		.cmd         (cmd)
	);

	// Voice table and result path.
	vpa_datapath #(
		.VOICES   (VOICES),
		.CHANNELS (CHANNELS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.event_item   (event_item),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result_item  (result_item)
	);

endmodule

// File: rtl/core/vpa_ctrl.sv
// ----------------------------------------------------------------------------
// vpa_ctrl
// Sequencer of the voice allocator: decodes, scans, acts and flushes, and runs config writes and the limit sweep.
// ----------------------------------------------------------------------------
module vpa_ctrl
	import vpa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       event_valid,
	output logic       event_stall,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  vpa_sts_t   sts,
	output vpa_cmd_t   cmd
);

	`include "assert_macros.svh"

	state_t state_q, state_n;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state and commands.
	always_comb begin
		state_n     = state_q;
		cmd         = '0;
		cfg_ready   = 1'b0;
		event_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				cfg_ready   = 1'b1;
				event_stall = cfg_valid;
				if (cfg_valid) begin
					cmd.cfg_we = 1'b1;
					if (cfg_index == CFG_VOICE_LIMIT) begin
						state_n = ST_SWEEP;
					end
				end else if (event_valid) begin
					cmd.load = 1'b1;
					state_n  = ST_PREP;
				end
			end
			ST_PREP: begin
				unique case (sts.kind)
					K_NOTE_ON, K_NOTE_OFF, K_SOUND_OFF, K_NOTES_OFF: state_n = ST_SCAN;
					K_PEDAL, K_FINISH: state_n = ST_ACT;
					default: state_n = ST_FLUSH;
				endcase
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_n = (sts.kind == K_NOTE_ON || sts.kind == K_NOTE_OFF) ?
						ST_ACT : ST_FLUSH;
				end else if (sts.go) begin
					cmd.step = 1'b1;
				end
			end
			ST_ACT: begin
				if (sts.go) begin
					cmd.act = 1'b1;
					state_n = (sts.kind == K_PEDAL && sts.pedal_rel) ? ST_SCAN : ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_n   = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	`VPA_ASSERT_NEXT(a_leave_idle, (state_q == ST_IDLE) && event_valid && !event_stall, state_q == ST_PREP)

endmodule

// File: rtl/core/vpa_datapath.sv
// ----------------------------------------------------------------------------
// vpa_datapath
// Voice table, pedals, counters, scan trackers and the result registers.
// ----------------------------------------------------------------------------
module vpa_datapath
	import vpa_pkg::*;
#(
	parameter int VOICES   = 32,
	parameter int CHANNELS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  event_t     event_item,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data,
	input  vpa_cmd_t   cmd,
	output vpa_sts_t   sts,
	input  logic       result_stall,
	output logic       result_valid,
	output result_t    result_item
);

	`include "assert_macros.svh"

	localparam int SW  = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int LW  = SW + 1;
	localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Configuration.
	logic [1:0] mode_q;
	logic       sus_en_q;
	logic [5:0] limit_q;

	// Voice table.
	logic [VOICES-1:0] held_q, sus_q, rel_q;
	logic [6:0]        note_q  [VOICES];
	logic [6:0]        vel_q   [VOICES];
	logic [3:0]        chn_q   [VOICES];
	logic [15:0]       stamp_q [VOICES];

	logic [CHANNELS-1:0] pedal_q;
	logic [15:0]         ctr_q, steals_q;
	logic [LW-1:0]       cnt_q;

	// Current event and scan trackers.
	event_t        item_q;
	kind_t         kind_q;
	logic [LW-1:0] scan_q;
	logic [5:0]    emit_cnt_q;
	logic          hit_q, free_q, vic_q;
	logic [SW-1:0] hit_idx_q, free_idx_q, vic_idx_q;
	logic [6:0]    hit_vel_q;
	logic [15:0]   hit_stamp_q, vic_key_q;

	// Result staging.
	logic    pend_valid_q, out_valid_q;
	result_t pend_q, out_q;

	logic [LW-1:0] lim;
	logic [SW-1:0] slot, fslot, tgt;
	logic          in_use_s, ch_match, fin_ok, fin_use;
	logic [15:0]   key, steals_inc;
	logic          ch_ok, pedal_now, pedal_was, any_others, sustain_go;
	logic [CHW-1:0] pch;
	logic          out_free, push, push_ok;
	result_t       res, tail_res;
	kind_t         kind_dec;

	// Effective voice limit, clamped to one and to VOICES.
	always_comb begin
		if (limit_q == 6'd0) begin
			lim = LW'(1);
		end else if ({1'b0, limit_q} > 7'(VOICES)) begin
			lim = LW'(VOICES);
		end else begin
			lim = LW'(limit_q);
		end
	end

	// Per-slot view at the scan index.
	assign slot     = scan_q[SW-1:0];
	assign in_use_s = held_q[slot] | sus_q[slot] | rel_q[slot];
	assign ch_match = chn_q[slot] == item_q.channel;

	always_comb begin
		unique case (steal_t'(mode_q))
			STEAL_OLDEST:    key = ctr_q - stamp_q[slot];
			STEAL_LOW_VEL:   key = 16'(MAX_VALUE - vel_q[slot]);
			STEAL_HIGH_NOTE: key = 16'(note_q[slot]);
			default:         key = 16'(MAX_VALUE - note_q[slot]);
		endcase
	end

	// Finished-slot and pedal decode.
	assign fin_ok     = 7'(item_q.voice_slot) < 7'(lim);
	assign fslot      = SW'(item_q.voice_slot);
	assign fin_use    = held_q[fslot] | sus_q[fslot] | rel_q[fslot];
	assign ch_ok      = {1'b0, item_q.channel} < 5'(CHANNELS);
	assign pch        = item_q.channel[CHW-1:0];
	assign pedal_now  = item_q.cc_value >= PEDAL_THRESHOLD;
	assign pedal_was  = ch_ok && pedal_q[pch];
	assign any_others = |(pedal_q & ~(CHANNELS'(1) << pch));
	assign sustain_go = sus_en_q && pedal_was;
	assign steals_inc = (steals_q == 16'hFFFF) ? steals_q : steals_q + 16'd1;
	assign tgt        = free_q ? free_idx_q : vic_idx_q;

	// Event class decode at load.
	always_comb begin
		unique case (op_t'(event_item.operation))
			OP_NOTE_ON:  kind_dec = (event_item.velocity == 7'd0) ? K_NOTE_OFF : K_NOTE_ON;
			OP_NOTE_OFF: kind_dec = K_NOTE_OFF;
			OP_CONTROL: begin
				if (event_item.cc_number == CC_SUSTAIN) begin
					kind_dec = K_PEDAL;
				end else if (event_item.cc_number == CC_SOUND_OFF) begin
					kind_dec = K_SOUND_OFF;
				end else if (event_item.cc_number == CC_NOTES_OFF) begin
					kind_dec = K_NOTES_OFF;
				end else begin
					kind_dec = K_NONE;
				end
			end
			default: kind_dec = K_FINISH;
		endcase
	end

	// Result beat produced by this cycle's step or action.
	always_comb begin
		push = 1'b0;
		res  = mk_res(5'd0, ACT_NONE, 7'd0, 7'd0, 16'd0, 6'(cnt_q), steals_q);
		if (cmd.step) begin
			unique case (kind_q)
				K_PEDAL: begin
					push = sus_q[slot];
					res  = mk_res(5'(slot), ACT_RELEASED, note_q[slot], vel_q[slot],
						stamp_q[slot], 6'(cnt_q), steals_q);
				end
				K_SOUND_OFF: begin
					push = in_use_s && ch_match;
					res  = mk_res(5'(slot), ACT_FREED, 7'd0, 7'd0, 16'd0,
						6'(cnt_q - LW'(1)), steals_q);
				end
				K_NOTES_OFF: begin
					push = held_q[slot] && ch_match;
					res  = mk_res(5'(slot), ACT_RELEASED, note_q[slot], vel_q[slot],
						stamp_q[slot], 6'(cnt_q), steals_q);
				end
				default: push = 1'b0;
			endcase
		end else if (cmd.act) begin
			unique case (kind_q)
				K_NOTE_OFF: begin
					push = 1'b1;
					if (hit_q) begin
						res = mk_res(5'(hit_idx_q), sustain_go ? ACT_SUSTAINED : ACT_RELEASED,
							item_q.note, hit_vel_q, hit_stamp_q, 6'(cnt_q), steals_q);
					end
				end
				K_NOTE_ON: begin
					push = 1'b1;
					if (hit_q) begin
						res = mk_res(5'(hit_idx_q), ACT_RETRIGGER, item_q.note,
							item_q.velocity, ctr_q, 6'(cnt_q), steals_q);
					end else if (free_q) begin
						res = mk_res(5'(free_idx_q), ACT_NEW, item_q.note, item_q.velocity,
							ctr_q, 6'(cnt_q + LW'(1)), steals_q);
					end else if (vic_q) begin
						res = mk_res(5'(vic_idx_q), ACT_STOLEN, item_q.note, item_q.velocity,
							ctr_q, 6'(cnt_q), steals_inc);
					end else begin
						res = mk_res(5'd0, ACT_FAILED, 7'd0, 7'd0, 16'd0, 6'(cnt_q), steals_q);
					end
				end
				K_FINISH: begin
					push = 1'b1;
					if (fin_ok) begin
						res = mk_res(5'(fslot), ACT_FREED, 7'd0, 7'd0, 16'd0,
							6'(cnt_q - LW'(fin_use)), steals_q);
					end
				end
				default: push = 1'b0;
			endcase
		end
	end

	// A beat is kept only while the result cap is not reached.
	assign push_ok  = push && emit_cnt_q < MAX_RESULTS;
	assign out_free = !out_valid_q || !result_stall;

	// Status to the controller.
	assign sts.kind       = kind_q;
	assign sts.scan_done  = scan_q >= lim;
	assign sts.sweep_last = scan_q == LW'(VOICES - 1);
	assign sts.go         = !pend_valid_q || out_free;
	assign sts.out_free   = out_free;
	assign sts.pedal_rel  = pedal_was && !pedal_now && !any_others;

	// Control state, flags and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= STEAL_OLDEST;
			sus_en_q   <= 1'b1;
			limit_q    <= 6'd32;
			held_q     <= '0;
			sus_q      <= '0;
			rel_q      <= '0;
			pedal_q    <= '0;
			ctr_q      <= 16'd1;
			steals_q   <= 16'd0;
			cnt_q      <= '0;
			kind_q     <= K_NONE;
			scan_q     <= '0;
			emit_cnt_q <= '0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			vic_q      <= 1'b0;
		end else begin
			if (cmd.load) begin
				kind_q     <= kind_dec;
				scan_q     <= '0;
				emit_cnt_q <= '0;
				hit_q      <= 1'b0;
				free_q     <= 1'b0;
				vic_q      <= 1'b0;
			end
			if (cmd.cfg_we) begin
				scan_q <= '0;
				unique case (cfg_index)
					CFG_STEAL_MODE:     mode_q   <= cfg_data[1:0];
					CFG_SUSTAIN_ENABLE: sus_en_q <= cfg_data[0];
					CFG_VOICE_LIMIT:    limit_q  <= cfg_data;
					default: ;
				endcase
			end
			// Clear every slot at or above a newly written limit.
			if (cmd.sweep) begin
				scan_q <= scan_q + LW'(1);
				if (scan_q >= lim) begin
					held_q[slot] <= 1'b0;
					sus_q[slot]  <= 1'b0;
					rel_q[slot]  <= 1'b0;
					cnt_q        <= cnt_q - LW'(in_use_s);
				end
			end
			if (cmd.step) begin
				scan_q <= scan_q + LW'(1);
				unique case (kind_q)
					K_NOTE_ON, K_NOTE_OFF: begin
						if (!hit_q && held_q[slot] && note_q[slot] == item_q.note && ch_match) begin
							hit_q <= 1'b1;
						end
						if (!free_q && !in_use_s) begin
							free_q <= 1'b1;
						end
						if (in_use_s && !sus_q[slot] && (!vic_q || key > vic_key_q)) begin
							vic_q <= 1'b1;
						end
					end
					K_PEDAL: begin
						if (sus_q[slot]) begin
							sus_q[slot] <= 1'b0;
							rel_q[slot] <= 1'b1;
						end
					end
					K_SOUND_OFF: begin
						if (in_use_s && ch_match) begin
							held_q[slot] <= 1'b0;
							sus_q[slot]  <= 1'b0;
							rel_q[slot]  <= 1'b0;
							cnt_q        <= cnt_q - LW'(1);
						end
					end
					K_NOTES_OFF: begin
						if (held_q[slot] && ch_match) begin
							held_q[slot] <= 1'b0;
							rel_q[slot]  <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (cmd.act) begin
				unique case (kind_q)
					K_NOTE_OFF: begin
						if (hit_q) begin
							held_q[hit_idx_q] <= 1'b0;
							if (sustain_go) begin
								sus_q[hit_idx_q] <= 1'b1;
								rel_q[hit_idx_q] <= 1'b0;
							end else begin
								rel_q[hit_idx_q] <= 1'b1;
							end
						end
					end
					K_NOTE_ON: begin
						if (hit_q) begin
							sus_q[hit_idx_q] <= 1'b0;
							rel_q[hit_idx_q] <= 1'b0;
							ctr_q            <= ctr_q + 16'd1;
						end else if (free_q || vic_q) begin
							held_q[tgt] <= 1'b1;
							sus_q[tgt]  <= 1'b0;
							rel_q[tgt]  <= 1'b0;
							ctr_q       <= ctr_q + 16'd1;
							if (free_q) begin
								cnt_q <= cnt_q + LW'(1);
							end else begin
								steals_q <= steals_inc;
							end
						end
					end
					K_FINISH: begin
						if (fin_ok) begin
							held_q[fslot] <= 1'b0;
							sus_q[fslot]  <= 1'b0;
							rel_q[fslot]  <= 1'b0;
							cnt_q         <= cnt_q - LW'(fin_use);
						end
					end
					K_PEDAL: begin
						if (ch_ok) begin
							pedal_q[pch] <= pedal_now;
						end
					end
					default: ;
				endcase
			end
			if (push_ok) begin
				emit_cnt_q <= emit_cnt_q + 6'd1;
			end
		end
	end

	// Voice payload and tracker payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= event_item;
		end
		if (cmd.step && (kind_q == K_NOTE_ON || kind_q == K_NOTE_OFF)) begin
			if (!hit_q && held_q[slot] && note_q[slot] == item_q.note && ch_match) begin
				hit_idx_q   <= slot;
				hit_vel_q   <= vel_q[slot];
				hit_stamp_q <= stamp_q[slot];
			end
			if (!free_q && !in_use_s) begin
				free_idx_q <= slot;
			end
			if (in_use_s && !sus_q[slot] && (!vic_q || key > vic_key_q)) begin
				vic_idx_q <= slot;
				vic_key_q <= key;
			end
		end
		if (cmd.act && kind_q == K_NOTE_ON) begin
			if (hit_q) begin
				vel_q[hit_idx_q]   <= item_q.velocity;
				stamp_q[hit_idx_q] <= ctr_q;
			end else if (free_q || vic_q) begin
				note_q[tgt]  <= item_q.note;
				vel_q[tgt]   <= item_q.velocity;
				chn_q[tgt]   <= item_q.channel;
				stamp_q[tgt] <= ctr_q;
			end
		end
	end

	// Final beat of an event: the pending beat, or a no-effect beat, marked last.
	always_comb begin
		tail_res = pend_valid_q ? pend_q :
			mk_res(5'd0, ACT_NONE, 7'd0, 7'd0, 16'd0, 6'(cnt_q), steals_q);
		tail_res.last = 1'b1;
	end

	// Pending beat and output register; the pending beat learns it is last at flush.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push_ok) begin
				pend_valid_q <= 1'b1;
				out_valid_q  <= pend_valid_q || (out_valid_q && result_stall);
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
				out_valid_q  <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			pend_q <= res;
			if (pend_valid_q) begin
				out_q <= pend_q;
			end
		end else if (cmd.flush) begin
			out_q <= tail_res;
		end
	end

	assign result_valid = out_valid_q;
	assign result_item  = out_q;

	`VPA_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= LW'(VOICES))
	`VPA_ASSERT_IMP(a_emit_cap, 1'b1, emit_cnt_q <= MAX_RESULTS)
	`VPA_ASSERT_NEXT(a_steal_mono, 1'b1, steals_q >= $past(steals_q))
	`VPA_ASSERT_NEXT(a_flush_empties, cmd.flush, !pend_valid_q && out_valid_q)

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the polyphonic voice allocator. A behavioral
// model of the voice table predicts every result beat of each accepted
// event; a checker compares result beats with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	import vpa_pkg::*;

	localparam int NV = 32;
	localparam int NCH = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	logic       clk;
	logic       arst_n;
	logic       event_valid;
	logic       event_stall;
	event_t     event_item;
	logic       result_valid;
	logic       result_stall;
	result_t    result_item;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [5:0] cfg_data;

	poly_voice_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.event_valid(event_valid), .event_stall(event_stall), .event_item(event_item),
		.result_valid(result_valid), .result_stall(result_stall),
		.result_item(result_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predicted voice table and registers.
	logic [1:0]  m_mode;
	logic        m_sus_en;
	logic [5:0]  m_limit;
	logic [6:0]  v_note [NV];
	logic [6:0]  v_vel [NV];
	logic [3:0]  v_ch [NV];
	logic        v_held [NV];
	logic        v_sus [NV];
	logic        v_rel [NV];
	logic [15:0] v_stamp [NV];
	logic        pedal [NCH];
	logic [15:0] stamp_ctr;
	logic [15:0] steal_ctr;

	result_t pending_results [$];
	result_t beat_buf [$];
	int      errors = 0;
	int      idle_cycles = 0;
	bit      done_flag;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int lim_eff();
		if (m_limit < 1) return 1;
		if (m_limit > NV) return NV;
		return m_limit;
	endfunction

	function automatic bit busy(int i);
		return v_held[i] || v_sus[i] || v_rel[i];
	endfunction

	function automatic void clear_voice(int i);
		v_note[i] = '0; v_vel[i] = '0; v_ch[i] = '0;
		v_held[i] = 0; v_sus[i] = 0; v_rel[i] = 0; v_stamp[i] = '0;
	endfunction

	function automatic void model_reset();
		m_mode = STEAL_OLDEST; m_sus_en = 1; m_limit = 6'd32;
		for (int i = 0; i < NV; i++) clear_voice(i);
		for (int c = 0; c < NCH; c++) pedal[c] = 0;
		stamp_ctr = 16'd1; steal_ctr = '0;
	endfunction

	// Appends one predicted beat for this event, unless the result cap is reached.
	function automatic void add_beat(int slot, action_t act);
		result_t r;
		int cnt;
		int lim;
		cnt = 0;
		lim = lim_eff();
		if (beat_buf.size() >= MAX_RESULTS) return;
		for (int i = 0; i < lim; i++) if (busy(i)) cnt++;
		r = '0;
		if (act != ACT_NONE && act != ACT_FAILED) begin
			r.voice_index = slot[4:0];
			r.out_note = v_note[slot];
			r.out_velocity = v_vel[slot];
			r.voice_id = v_stamp[slot];
		end
		r.action = act;
		r.active_count = cnt[5:0];
		r.steal_count = steal_ctr;
		beat_buf = {beat_buf, r};
	endfunction

	function automatic int held_match(logic [6:0] nt, logic [3:0] ch);
		for (int i = 0; i < lim_eff(); i++)
			if (v_held[i] && v_note[i] == nt && v_ch[i] == ch) return i;
		return -1;
	endfunction

	function automatic void stamp_voice(int i);
		v_stamp[i] = stamp_ctr;
		stamp_ctr = stamp_ctr + 16'd1;
	endfunction

	function automatic int choose_victim();
		int best;
		int best_key;
		int key;
		logic [15:0] age;
		best = -1;
		best_key = 0;
		for (int i = 0; i < lim_eff(); i++) begin
			if (!busy(i) || v_sus[i]) continue;
			age = stamp_ctr - v_stamp[i];
			case (m_mode)
				STEAL_OLDEST: key = age;
				STEAL_LOW_VEL: key = 127 - v_vel[i];
				STEAL_HIGH_NOTE: key = v_note[i];
				default: key = 127 - v_note[i];
			endcase
			if (best < 0 || key > best_key) begin
				best = i; best_key = key;
			end
		end
		return best;
	endfunction

	function automatic void note_off(logic [6:0] nt, logic [3:0] ch);
		int v;
		v = held_match(nt, ch);
		if (v < 0) begin
			add_beat(0, ACT_NONE);
			return;
		end
		v_held[v] = 0;
		if (m_sus_en && pedal[ch]) begin
			v_sus[v] = 1; v_rel[v] = 0;
			add_beat(v, ACT_SUSTAINED);
		end else begin
			v_rel[v] = 1;
			add_beat(v, ACT_RELEASED);
		end
	endfunction

	function automatic void note_on(logic [6:0] nt, logic [6:0] vl, logic [3:0] ch);
		int v;
		int i;
		action_t act;
		act = ACT_NEW;
		v = held_match(nt, ch);
		if (v >= 0) begin
			v_vel[v] = vl; v_rel[v] = 0; v_sus[v] = 0;
			stamp_voice(v);
			add_beat(v, ACT_RETRIGGER);
			return;
		end
		for (i = 0; i < lim_eff(); i++) if (!busy(i)) break;
		if (i >= lim_eff()) begin
			v = choose_victim();
			if (v < 0) begin
				add_beat(0, ACT_FAILED);
				return;
			end
			i = v;
			if (steal_ctr != 16'hFFFF) steal_ctr++;
			act = ACT_STOLEN;
		end
		v_note[i] = nt; v_vel[i] = vl; v_ch[i] = ch;
		v_held[i] = 1; v_sus[i] = 0; v_rel[i] = 0;
		stamp_voice(i);
		add_beat(i, act);
	endfunction

	function automatic void control(logic [6:0] num, logic [6:0] val, logic [3:0] ch);
		bit was;
		bit any;
		any = 0;
		if (num == CC_SUSTAIN) begin
			was = pedal[ch];
			pedal[ch] = (val >= PEDAL_THRESHOLD);
			if (was && !pedal[ch]) begin
				for (int c = 0; c < NCH; c++) if (pedal[c]) any = 1;
				if (!any)
					for (int i = 0; i < lim_eff(); i++)
						if (v_sus[i]) begin
							v_sus[i] = 0; v_rel[i] = 1;
							add_beat(i, ACT_RELEASED);
						end
			end
		end else if (num == CC_SOUND_OFF) begin
			for (int i = 0; i < lim_eff(); i++)
				if (busy(i) && v_ch[i] == ch) begin
					clear_voice(i);
					add_beat(i, ACT_FREED);
				end
		end else if (num == CC_NOTES_OFF) begin
			for (int i = 0; i < lim_eff(); i++)
				if (v_held[i] && v_ch[i] == ch) begin
					v_held[i] = 0; v_rel[i] = 1;
					add_beat(i, ACT_RELEASED);
				end
		end
		if (beat_buf.size() == 0) add_beat(0, ACT_NONE);
	endfunction

	// Predicts the result beats of one event and queues them.
	function automatic void predict_event(event_t e);
		beat_buf.delete();
		case (e.operation)
			OP_NOTE_ON: begin
				if (e.velocity == 0) note_off(e.note, e.channel);
				else note_on(e.note, e.velocity, e.channel);
			end
			OP_NOTE_OFF: note_off(e.note, e.channel);
			OP_CONTROL: control(e.cc_number, e.cc_value, e.channel);
			default: begin
				if (e.voice_slot < lim_eff()) begin
					clear_voice(e.voice_slot);
					add_beat(e.voice_slot, ACT_FREED);
				end else begin
					add_beat(0, ACT_NONE);
				end
			end
		endcase
		beat_buf[beat_buf.size() - 1].last = 1'b1;
		pending_results = {pending_results, beat_buf};
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// Result stall: random per beat, with stretches of none.
	initial begin
		int w;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall) begin
				w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
				if (w > 0) begin
					result_stall <= 1'b1;
					repeat (w) @(posedge clk);
					result_stall <= 1'b0;
				end
			end
		end
	end

	// Checker for every accepted result beat.
	always @(posedge clk) begin
		result_t w;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$display("unexpected result beat");
				errors++;
			end else begin
				w = pending_results.pop_front();
				if (result_item.voice_index !== w.voice_index)
					report_mismatch("voice_index", result_item.voice_index, w.voice_index);
				if (result_item.action !== w.action)
					report_mismatch("action", result_item.action, w.action);
				if (result_item.out_note !== w.out_note)
					report_mismatch("out_note", result_item.out_note, w.out_note);
				if (result_item.out_velocity !== w.out_velocity)
					report_mismatch("out_velocity", result_item.out_velocity,
						w.out_velocity);
				if (result_item.voice_id !== w.voice_id)
					report_mismatch("voice_id", result_item.voice_id, w.voice_id);
				if (result_item.active_count !== w.active_count)
					report_mismatch("active_count", result_item.active_count,
						w.active_count);
				if (result_item.steal_count !== w.steal_count)
					report_mismatch("steal_count", result_item.steal_count,
						w.steal_count);
				if (result_item.last !== w.last)
					report_mismatch("last", result_item.last, w.last);
			end
		end
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if ((event_valid && !event_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready) || done_flag)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Sends one event after a random gap and predicts it on acceptance.
	// Valid stays up after acceptance until the next send or a drain decides.
	task automatic send_event(event_t e);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			event_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		event_item <= e;
		event_valid <= 1'b1;
		do @(posedge clk); while (event_stall);
		predict_event(e);
	endtask

	function automatic event_t mk_event(op_t op, int nt, int vl, int ch, int num,
			int val, int slot);
		event_t e;
		e.operation = op; e.note = 7'(nt); e.velocity = 7'(vl); e.channel = 4'(ch);
		e.cc_number = 7'(num); e.cc_value = 7'(val); e.voice_slot = 5'(slot);
		return e;
	endfunction

	task automatic drain();
		event_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (NV + 8) @(posedge clk);
	endtask

	// Writes one register while the block is idle.
	task automatic write_reg(logic [1:0] idx, logic [5:0] val);
		drain();
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_STEAL_MODE: m_mode = val[1:0];
			CFG_SUSTAIN_ENABLE: m_sus_en = val[0];
			default: begin
				m_limit = val;
				for (int i = lim_eff(); i < NV; i++) clear_voice(i);
			end
		endcase
		repeat (NV + 4) @(posedge clk);
	endtask

	task automatic test_directed();
		send_event(mk_event(OP_NOTE_ON, 0, 127, 0, 0, 0, 0));
		send_event(mk_event(OP_NOTE_ON, 127, 1, 15, 127, 127, 31));
		send_event(mk_event(OP_NOTE_ON, 0, 100, 0, 0, 0, 0));
		send_event(mk_event(OP_NOTE_ON, 127, 0, 15, 0, 0, 0));
		send_event(mk_event(OP_NOTE_OFF, 5, 0, 3, 0, 0, 0));
		send_event(mk_event(OP_CONTROL, 0, 0, 2, CC_SUSTAIN, 127, 0));
		send_event(mk_event(OP_CONTROL, 0, 0, 5, CC_SUSTAIN, 64, 0));
		send_event(mk_event(OP_NOTE_ON, 60, 50, 2, 0, 0, 0));
		send_event(mk_event(OP_NOTE_OFF, 60, 50, 2, 0, 0, 0));
		send_event(mk_event(OP_CONTROL, 0, 0, 2, CC_SUSTAIN, 0, 0));
		send_event(mk_event(OP_CONTROL, 0, 0, 5, CC_SUSTAIN, 63, 0));
		send_event(mk_event(OP_NOTE_ON, 61, 70, 4, 0, 0, 0));
		send_event(mk_event(OP_NOTE_ON, 62, 70, 4, 0, 0, 0));
		send_event(mk_event(OP_CONTROL, 0, 0, 4, CC_NOTES_OFF, 0, 0));
		send_event(mk_event(OP_CONTROL, 0, 0, 4, CC_SOUND_OFF, 0, 0));
		send_event(mk_event(OP_CONTROL, 0, 0, 0, 7, 100, 0));
		send_event(mk_event(OP_FINISHED, 0, 0, 0, 0, 0, 0));
		send_event(mk_event(OP_FINISHED, 0, 0, 0, 0, 0, 31));
	endtask

	// Small voice limit: stealing under every mode, and all slots sustained.
	task automatic test_stealing();
		write_reg(CFG_VOICE_LIMIT, 6'd0);
		send_event(mk_event(OP_NOTE_ON, 10, 10, 1, 0, 0, 0));
		send_event(mk_event(OP_NOTE_ON, 11, 10, 1, 0, 0, 0));
		send_event(mk_event(OP_FINISHED, 0, 0, 0, 0, 0, 1));
		write_reg(CFG_VOICE_LIMIT, 6'd3);
		for (int m = 0; m < 4; m++) begin
			write_reg(CFG_STEAL_MODE, 6'(m));
			for (int k = 0; k < 5; k++)
				send_event(mk_event(OP_NOTE_ON, $urandom_range(0, 127),
					$urandom_range(1, 127), $urandom_range(0, 1), 0, 0, 0));
		end
		send_event(mk_event(OP_CONTROL, 0, 0, 0, CC_SUSTAIN, 100, 0));
		for (int k = 0; k < 3; k++) begin
			send_event(mk_event(OP_NOTE_ON, 20 + k, 9, 0, 0, 0, 0));
			send_event(mk_event(OP_NOTE_OFF, 20 + k, 0, 0, 0, 0, 0));
		end
		send_event(mk_event(OP_NOTE_ON, 90, 9, 0, 0, 0, 0));
		send_event(mk_event(OP_CONTROL, 0, 0, 0, CC_SUSTAIN, 0, 0));
		write_reg(CFG_VOICE_LIMIT, 6'd63);
	endtask

	// Random phases over several register settings.
	task automatic test_random();
		event_t e;
		logic [63:0] raw;
		for (int phase = 0; phase < 4; phase++) begin
			write_reg(CFG_STEAL_MODE, 6'($urandom_range(0, 3)));
			write_reg(CFG_SUSTAIN_ENABLE, 6'(phase[0]));
			write_reg(CFG_VOICE_LIMIT, (phase == 3) ? 6'd32 : 6'($urandom_range(1, 8)));
			for (int k = 0; k < 20; k++) begin
				raw = {$urandom, $urandom};
				e = raw[$bits(event_t)-1:0];
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						e.operation = OP_NOTE_ON;
						e.note = 7'($urandom_range(60, 67));
						e.channel = 4'($urandom_range(0, 2));
					end
					4, 5: begin
						e.operation = OP_NOTE_OFF;
						e.note = 7'($urandom_range(60, 67));
						e.channel = 4'($urandom_range(0, 2));
					end
					6, 7: begin
						e.operation = OP_CONTROL;
						e.channel = 4'($urandom_range(0, 2));
						case ($urandom_range(0, 4))
							0, 1: e.cc_number = CC_SUSTAIN;
							2: e.cc_number = CC_NOTES_OFF;
							3: e.cc_number = CC_SOUND_OFF;
							default: ;
						endcase
					end
					8: e.operation = OP_FINISHED;
					default: ;
				endcase
				send_event(e);
				if (k == 10) drain();
			end
		end
	endtask

	initial begin
		done_flag = 0;
		model_reset();
		arst_n = 1'b0;
		event_valid <= 1'b0;
		event_item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_stealing();
		test_random();
		drain();
		done_flag = 1;
		if (errors == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/vpa_pkg.sv
rtl/core/vpa_ctrl.sv
rtl/core/vpa_datapath.sv
rtl/core/poly_voice_allocator.sv
tb/sv/tb.sv
